FILE: rtl/kop_pkg.sv
// shared types, constants and rounding helper for the kepler orbit position solver
package kop_pkg;

  localparam int ECC_BITS    = 24;
  localparam int DIST_BITS   = 32;
  localparam int TOL_BITS    = 16;
  localparam int CAP_BITS    = 10;
  localparam int CORDIC_STEPS = 30;
  localparam int CW          = 36;  // cordic x/y datapath
  localparam int ZW          = 34;  // cordic phase accumulator
  localparam int MW          = 34;  // shared multiplier operand width

  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd11930;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 10'd1000;

  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_CAP       = 1'b1;

  localparam logic signed [CW-1:0] CORDIC_KINV = 36'sd652032874;
  localparam logic signed [MW-1:0] RADQ32      = 34'sd683565276;

  localparam logic [29:0] ATAN_TAB [CORDIC_STEPS] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
  };

  typedef struct packed {
    logic start;
    logic vector;
  } cordic_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_COR_GO, ST_COR_WAIT, ST_ES, ST_EC, ST_U, ST_TU, ST_TQ, ST_RAD,
    ST_EA0, ST_NW_GO, ST_NES, ST_NEC, ST_NRAD, ST_NF, ST_DIV_GO, ST_DIV_WAIT,
    ST_NUPD, ST_FEC, ST_FD, ST_SQ_INIT, ST_SQ, ST_SY, ST_SY2, ST_RR, ST_RR2,
    ST_PER, ST_APH, ST_DONE
  } state_t;

  // divide by 2^k, rounding half away from zero
  function automatic logic signed [67:0] rnd(input logic signed [67:0] v, input int k);
    logic [67:0] mag;
    logic [67:0] r;
    mag = v[67] ? 68'(-v) : 68'(v);
    r = (mag + (68'd1 << (k - 1))) >> k;
    return v[67] ? -$signed(r) : $signed(r);
  endfunction

endpackage

FILE: rtl/kop_in_if.sv
// input item channel of the orbit position solver
interface kop_in_if import kop_pkg::*; #(parameter int ANGLE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] mean_anomaly;
  logic [ECC_BITS-1:0]   eccentricity;
  logic [DIST_BITS-1:0]  semi_major_axis;

  modport source(output valid, mean_anomaly, eccentricity, semi_major_axis, input ready);
  modport sink(input valid, mean_anomaly, eccentricity, semi_major_axis, output ready);
endinterface

FILE: rtl/kop_out_if.sv
// result item channel of the orbit position solver
interface kop_out_if import kop_pkg::*; #(parameter int ANGLE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] eccentric_anomaly;
  logic [ANGLE_BITS-1:0] true_anomaly;
  logic [DIST_BITS:0]    radius;
  logic [DIST_BITS-1:0]  perihelion_distance;
  logic [DIST_BITS:0]    aphelion_distance;
  logic                  not_converged;

  modport source(output valid, eccentric_anomaly, true_anomaly, radius,
                 perihelion_distance, aphelion_distance, not_converged, input ready);
  modport sink(input valid, eccentric_anomaly, true_anomaly, radius,
               perihelion_distance, aphelion_distance, not_converged, output ready);
endinterface

FILE: rtl/kop_cordic.sv
// iterative cordic: rotation gives cos/sin of a phase, vectoring gives the phase of (x, y)
module kop_cordic import kop_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_req_t          req,
  input  logic [31:0]          phase,
  input  logic signed [CW-1:0] xin,
  input  logic signed [CW-1:0] yin,
  output logic signed [CW-1:0] cos_out,
  output logic signed [CW-1:0] sin_out,
  output logic [31:0]          angle,
  output logic                 done
);

  logic                 busy;
  logic [4:0]           i;
  logic                 vec;
  logic                 neg;
  logic                 zero;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;

  logic signed [ZW-1:0] zs;
  logic signed [ZW-1:0] at;
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic                 up;

  localparam logic signed [ZW-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [ZW-1:0] HALF    = 34'sd2147483648;

  always_comb begin
    zs = $signed({{(ZW-32){phase[31]}}, phase});
    at = $signed({{(ZW-30){1'b0}}, ATAN_TAB[i]});
    sx = x >>> i;
    sy = y >>> i;
    up = vec ? !(y > 0) : !z[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 5'd1;
        if (i == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      vec <= req.vector;
      if (!req.vector) begin
        x    <= CORDIC_KINV;
        y    <= '0;
        zero <= 1'b0;
        // fold into the right half plane
        if (zs > QUARTER) begin
          z   <= zs - HALF;
          neg <= 1'b1;
        end else if (zs < -QUARTER) begin
          z   <= zs + HALF;
          neg <= 1'b1;
        end else begin
          z   <= zs;
          neg <= 1'b0;
        end
      end else begin
        neg  <= 1'b0;
        zero <= (xin == '0) && (yin == '0);
        if (xin < 0) begin
          x <= -xin;
          y <= -yin;
          z <= HALF;
        end else begin
          x <= xin;
          y <= yin;
          z <= '0;
        end
      end
    end else if (busy) begin
      if (up) begin
        x <= x - sy;
        y <= y + sx;
        z <= z - at;
      end else begin
        x <= x + sy;
        y <= y - sx;
        z <= z + at;
      end
    end
  end

  assign cos_out = neg ? -x : x;
  assign sin_out = neg ? -y : y;
  assign angle   = zero ? 32'd0 : z[31:0];

endmodule

FILE: rtl/kop_div.sv
// restoring divider, one quotient bit a cycle, keeps the low quotient bits
module kop_div import kop_pkg::*; #(
  parameter int NW = 65,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [31:0]   den,
  output logic [QW-1:0] quo,
  output logic          done
);

  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic            busy;
  logic [NW-1:0]   nsh;
  logic [31:0]     rem;
  logic [32:0]     r2;
  logic            ge;

  always_comb begin
    r2 = {rem, nsh[NW-1]};
    ge = r2 >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh <= num;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      nsh <= nsh << 1;
      rem <= ge ? 32'(r2 - {1'b0, den}) : r2[31:0];
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule

FILE: rtl/kepler_orbit_position_solver.sv
// Kepler orbit position solver: mean anomaly, eccentricity and semi-major axis in,
// eccentric anomaly, true anomaly, radius and apsis distances out.
//
// din carries one item (mean_anomaly, eccentricity, semi_major_axis); dout carries
// one result item for every input item, in order. Both use valid/ready; an item
// moves on a clock edge with valid and ready high. cfg_we/cfg_index/cfg_data write
// tolerance (index 0) and iteration_cap (index 1); the user must write them only
// while the block is idle, which the block itself does not enforce. One item is
// handled at a time; din.ready is high only in the idle state. Each item takes a
// first estimate, then one cordic pass and one divide per Newton step, then the
// tail. The cordic is shared by all passes and the divider is bit-serial.
// The result sits in an output register; if dout is stalled the next item is
// still taken and worked on, and waits in its last state until the register frees.
// Synchronous reset clears the sequencer, empties the output register and loads
// tolerance 11930 and iteration_cap 1000.
module kepler_orbit_position_solver import kop_pkg::*; #(
  parameter int ANGLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  kop_in_if.sink              din,
  kop_out_if.source           dout,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [TOL_BITS-1:0] cfg_data
);

  localparam int A     = ANGLE_BITS;
  localparam int FW    = A + 3;
  localparam int NW    = FW + 30;
  localparam int PH_DN = (A >= 32) ? A - 32 : 0;
  localparam int PH_UP = (A < 32) ? 32 - A : 0;
  localparam logic [63:0] PH_RND = (A > 32) ? (64'd1 << (A - 33)) : 64'd0;
  localparam logic [63:0] FR_RND = (A < 32) ? (64'd1 << (31 - A)) : 64'd0;
  localparam int ANG_SH = 62 - A;

  function automatic logic [31:0] to_phase(input logic [A-1:0] ang);
    logic [63:0] t;
    t = 64'(ang) + PH_RND;
    return 32'((t >> PH_DN) << PH_UP);
  endfunction

  function automatic logic [A-1:0] from_phase(input logic [31:0] p);
    logic [63:0] t;
    t = 64'(p) + FR_RND;
    return A'((t >> PH_UP) << PH_DN);
  endfunction

  state_t state, state_next, ret;

  logic [TOL_BITS-1:0]  tol;
  logic [CAP_BITS-1:0]  cap;
  logic [CAP_BITS-1:0]  cap_eff;
  logic [CAP_BITS-1:0]  n;

  logic [A-1:0]         m_r;
  logic [ECC_BITS-1:0]  e_r;
  logic [DIST_BITS-1:0] a_r;
  logic [A-1:0]         ea_r;
  logic [A-1:0]         e0_r;
  logic [A-1:0]         cor_ang;
  logic                 cor_vec;
  logic signed [MW-1:0] t_r;
  logic signed [MW-1:0] u_r;
  logic signed [MW-1:0] q_r;
  logic signed [CW-1:0] x_r;
  logic signed [CW-1:0] y_r;
  logic                 fneg;
  logic [FW-1:0]        fmag;
  logic                 nc_r;
  logic [48:0]          sv;
  logic [48:0]          sr;
  logic [4:0]           k;
  logic [DIST_BITS:0]   rad_r;
  logic [DIST_BITS-1:0] peri_r;
  logic [DIST_BITS:0]   aph_r;
  logic [A-1:0]         tru_r;

  logic signed [MW-1:0] opa;
  logic signed [MW-1:0] opb;
  logic signed [67:0]   prod;

  cordic_req_t          cor_req;
  logic signed [CW-1:0] cor_cos;
  logic signed [CW-1:0] cor_sin;
  logic [31:0]          cor_angle;
  logic                 cor_done;
  logic                 div_start;
  logic [A-1:0]         div_quo;
  logic                 div_done;

  logic signed [67:0]   rnd24;
  logic signed [67:0]   rnd30;
  logic signed [67:0]   rnd_ang;
  logic signed [67:0]   d_raw;
  logic signed [MW-1:0] d_newton;
  logic signed [MW-1:0] d_rad;
  logic [A-1:0]         ea_first;
  logic [A-1:0]         diff;
  logic signed [FW-1:0] f;
  logic [A-1:0]         qa;
  logic [A-1:0]         ch;
  logic                 ch_ge;
  logic                 cont;
  logic [48:0]          trial;
  logic [48:0]          bitv;
  logic signed [MW-1:0] e34;
  logic signed [MW-1:0] a34;
  logic                 out_free;

  kop_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .req     (cor_req),
    .phase   (to_phase(cor_ang)),
    .xin     (x_r),
    .yin     (y_r),
    .cos_out (cor_cos),
    .sin_out (cor_sin),
    .angle   (cor_angle),
    .done    (cor_done)
  );

  kop_div #(.NW(NW), .QW(A)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({fmag, 30'd0}),
    .den   (u_r[31:0]),
    .quo   (div_quo),
    .done  (div_done)
  );

  always_comb begin
    cap_eff  = (cap == '0) ? CAP_BITS'(1) : cap;
    e34      = $signed({{(MW-ECC_BITS){1'b0}}, e_r});
    a34      = $signed({{(MW-DIST_BITS){1'b0}}, a_r});
    rnd24    = rnd(prod, 24);
    rnd30    = rnd(prod, 30);
    rnd_ang  = rnd(prod, ANG_SH);
    d_raw    = 68'sd1073741824 - rnd24;
    // newton divisor held in [1, 2^31], radius factor in [0, 2^31]
    if (d_raw < 68'sd1)               d_newton = 34'sd1;
    else if (d_raw > 68'sd2147483648) d_newton = 34'sd2147483648;
    else                              d_newton = MW'(d_raw);
    if (d_raw < 68'sd0)               d_rad = '0;
    else if (d_raw > 68'sd2147483648) d_rad = 34'sd2147483648;
    else                              d_rad = MW'(d_raw);
    ea_first = m_r + A'(rnd_ang);
    diff     = e0_r - m_r;
    f        = $signed({{3{diff[A-1]}}, diff}) - FW'(rnd_ang);
    qa       = fneg ? A'(-div_quo) : div_quo;
    ch       = qa[A-1] ? A'(-qa) : qa;
    ch_ge    = 64'(ch) >= 64'(tol);
    cont     = ch_ge && ((n + 1'b1) < cap_eff);
    bitv     = 49'd1 << {k, 1'b0};
    trial    = sr + bitv;
    out_free = !dout.valid || dout.ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (din.valid) state_next = ST_COR_GO;
      ST_COR_GO:   state_next = ST_COR_WAIT;
      ST_COR_WAIT: if (cor_done) state_next = ret;
      ST_ES:       state_next = ST_EC;
      ST_EC:       state_next = ST_U;
      ST_U:        state_next = ST_TU;
      ST_TU:       state_next = ST_TQ;
      ST_TQ:       state_next = ST_RAD;
      ST_RAD:      state_next = ST_EA0;
      ST_EA0:      state_next = (tol == '0) ? ST_COR_GO : ST_NW_GO;
      ST_NW_GO:    state_next = ST_COR_GO;
      ST_NES:      state_next = ST_NEC;
      ST_NEC:      state_next = ST_NRAD;
      ST_NRAD:     state_next = ST_NF;
      ST_NF:       state_next = ST_DIV_GO;
      ST_DIV_GO:   state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_NUPD;
      ST_NUPD:     state_next = cont ? ST_NW_GO : ST_COR_GO;
      ST_FEC:      state_next = ST_FD;
      ST_FD:       state_next = ST_SQ_INIT;
      ST_SQ_INIT:  state_next = ST_SQ;
      ST_SQ:       if (k == '0) state_next = ST_SY;
      ST_SY:       state_next = ST_SY2;
      ST_SY2:      state_next = ST_COR_GO;
      ST_RR:       state_next = ST_RR2;
      ST_RR2:      state_next = ST_PER;
      ST_PER:      state_next = ST_APH;
      ST_APH:      state_next = ST_DONE;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and shared multiplier operands
  always_comb begin
    din.ready      = 1'b0;
    cor_req.start  = 1'b0;
    cor_req.vector = cor_vec;
    div_start      = 1'b0;
    opa            = '0;
    opb            = '0;
    case (state)
      ST_IDLE:   din.ready = 1'b1;
      ST_COR_GO: cor_req.start = 1'b1;
      ST_DIV_GO: div_start = 1'b1;
      ST_ES, ST_NES: begin
        opa = e34;
        opb = MW'(cor_sin);
      end
      ST_EC, ST_NEC, ST_FEC: begin
        opa = e34;
        opb = MW'(cor_cos);
      end
      ST_TU: begin
        opa = t_r;
        opb = u_r;
      end
      ST_RAD: begin
        opa = q_r;
        opb = RADQ32;
      end
      ST_NRAD: begin
        opa = t_r;
        opb = RADQ32;
      end
      ST_FD: begin
        opa = e34;
        opb = e34;
      end
      ST_SY: begin
        opa = $signed({{(MW-25){1'b0}}, sr[24:0]});
        opb = MW'(cor_sin);
      end
      ST_RR: begin
        opa = a34;
        opb = u_r;
      end
      ST_RR2: begin
        opa = a34;
        opb = MW'(34'sd16777216 - e34);
      end
      ST_PER: begin
        opa = a34;
        opb = MW'(34'sd16777216 + e34);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      tol   <= TOL_RESET;
      cap   <= CAP_RESET;
      n     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_TOLERANCE: tol <= cfg_data;
          REG_CAP:       cap <= cfg_data[CAP_BITS-1:0];
          default:       tol <= tol;
        endcase
      end
      case (state)
        ST_IDLE:  if (din.valid) ret <= ST_ES;
        ST_EA0: begin
          n <= '0;
          if (tol == '0) ret <= ST_FEC;
        end
        ST_NW_GO: ret <= ST_NES;
        ST_NUPD: begin
          n <= n + 1'b1;
          if (!cont) ret <= ST_FEC;
        end
        ST_SY2:   ret <= ST_RR;
        default:  ret <= ret;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (din.valid) begin
        m_r     <= din.mean_anomaly;
        e_r     <= din.eccentricity;
        a_r     <= din.semi_major_axis;
        cor_ang <= din.mean_anomaly;
        cor_vec <= 1'b0;
      end
      ST_EC:  t_r <= MW'(rnd24);
      ST_U:   u_r <= MW'(68'sd1073741824 + rnd24);
      ST_TQ:  q_r <= MW'(rnd30);
      ST_EA0: begin
        ea_r    <= ea_first;
        cor_ang <= ea_first;
        nc_r    <= 1'b0;
      end
      ST_NW_GO: begin
        e0_r    <= ea_r;
        cor_ang <= ea_r;
      end
      ST_NEC:  t_r <= MW'(rnd24);
      ST_NRAD: u_r <= d_newton;
      ST_NF: begin
        fneg <= f[FW-1];
        fmag <= f[FW-1] ? FW'(-f) : FW'(f);
      end
      ST_NUPD: begin
        ea_r    <= e0_r - qa;
        cor_ang <= e0_r - qa;
        nc_r    <= ch_ge;
      end
      ST_FD: begin
        u_r <= d_rad;
        x_r <= cor_cos - $signed({6'd0, e_r, 6'd0});
      end
      ST_SQ_INIT: begin
        sv <= 49'h1_0000_0000_0000 - prod[48:0];
        sr <= '0;
        k  <= 5'd24;
      end
      ST_SQ: begin
        k <= k - 5'd1;
        if (sv >= trial) begin
          sv <= sv - trial;
          sr <= (sr >> 1) + bitv;
        end else begin
          sr <= sr >> 1;
        end
      end
      ST_SY2: begin
        y_r     <= CW'(rnd24);
        cor_vec <= 1'b1;
      end
      ST_RR2: rad_r  <= 33'((prod + 68'sd536870912) >>> 30);
      ST_PER: peri_r <= 32'((prod + 68'sd8388608) >>> 24);
      ST_APH: begin
        aph_r <= 33'((prod + 68'sd8388608) >>> 24);
        tru_r <= from_phase(cor_angle);
      end
      default: begin
        m_r <= m_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      dout.eccentric_anomaly   <= ea_r;
      dout.true_anomaly        <= tru_r;
      dout.radius              <= rad_r;
      dout.perihelion_distance <= peri_r;
      dout.aphelion_distance   <= aph_r;
      dout.not_converged       <= nc_r;
    end
  end

  a_cor_done_waited: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> state == ST_COR_WAIT)
    else $error("cordic finished outside its wait state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_NUPD |-> n < cap_eff)
    else $error("newton step count passed the cap");

  a_nc_needs_tol: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free && nc_r) |-> tol != '0)
    else $error("non-convergence flagged with refinement off");

endmodule
